FILE: sv/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants for the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int NUM_VOICES = 16;
    localparam int MAX_FRAMES = 1024;
    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CW = $clog2(NUM_VOICES + 1);
    localparam logic [15:0] PHASE_FULL = 16'hFFFF;
    localparam logic [15:0] ENV_STEP_RST = 16'd171;
    localparam logic [15:0] THRESH_RST = 16'd41;

    localparam logic [0:0] CFG_ENV_STEP = 1'b0;
    localparam logic [0:0] CFG_THRESH = 1'b1;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_PEDAL    = 2'd2,
        OP_TICK     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ATTACK  = 2'd1,
        MODE_SUSTAIN = 2'd2,
        MODE_RELEASE = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [31:0] start;
        logic        frozen;
        logic [15:0] phase;
        logic        up;
    } voice_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_ALLOC, ST_FIX, ST_OUT
    } state_t;

    typedef struct packed {
        logic            we;
        logic [VW-1:0]   waddr;
        voice_t          wdata;
        logic [VW-1:0]   raddr;
    } mem_ctl_t;

endpackage

FILE: sv/pva_voice_ram.sv
// ----------------------------------------------------------------------------
// pva_voice_ram
// Voice table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pva_voice_ram
    import pva_pkg::*;
(
    input  logic     aclk,
    input  mem_ctl_t ctl,
    output voice_t   rdata
);

    voice_t mem [NUM_VOICES];

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rdata <= mem[ctl.raddr];
    end

endmodule

FILE: sv/poly_voice_allocator.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator
// Voice table with note on/off, sustain pedal and envelope tick operations.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_axis   in   op, note, velocity, pedal_held, now_pos, frame_count
// m_axis   out  voice_index, voice_valid, retriggered, stolen, retired mask, count
// cfg      in   env_step (0), retire_threshold (1)
// Every transaction walks the voice memory through the single read port;
// a note on walks it twice. After reset the memory is cleared one voice
// per cycle and no input is taken meanwhile. The result is held until
// m_axis_tready.
module poly_voice_allocator
    import pva_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], note[8:2], velocity[15:9], pedal_held[16], now_pos[48:17],
    // frame_count[59:49]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // voice_index[3:0], voice_valid[4], retriggered[5], stolen[6],
    // retired_mask[22:7], active_count[27:23]
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    state_t state_reg, state_next;
    logic [VW:0] clr_reg, clr_next;
    logic [VW:0] cnt_reg, cnt_next;
    logic pass_reg, pass_next;
    logic [15:0] step_reg, thr_reg;
    logic pedal_reg, pedal_next;
    op_t op_reg, op_next;
    logic [6:0] note_reg, note_next, vel_reg, vel_next;
    logic held_reg, held_next;
    logic [31:0] now_reg, now_next;
    logic [10:0] frm_reg, frm_next;
    logic [26:0] delta_reg, delta_next;
    logic [VW-1:0] pick_reg, pick_next, old_reg, old_next, idx_reg, idx_next;
    logic match_reg, match_next, free_reg, free_next, valid_reg, valid_next;
    logic [31:0] oldst_reg, oldst_next;
    logic [15:0] ret_reg, ret_next;
    logic [CW-1:0] act_reg, act_next;
    logic [31:0] out_reg, out_next;
    logic ov_reg, ov_next;
    mem_ctl_t ctl;
    voice_t rd, wv;
    logic [VW-1:0] ri;
    logic [27:0] sum;
    logic [15:0] ph;
    logic hit;

    pva_voice_ram u_ram (.aclk(aclk), .ctl(ctl), .rdata(rd));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;
    assign ri = cnt_reg[VW-1:0] - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FIX;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            pass_reg  <= 1'b0;
            step_reg  <= ENV_STEP_RST;
            thr_reg   <= THRESH_RST;
            pedal_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
            pedal_reg <= pedal_next;
            ov_reg    <= ov_next;
            if (cfg_we && cfg_addr == CFG_ENV_STEP) begin
                step_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == CFG_THRESH) begin
                thr_reg <= cfg_wdata;
            end
        end
        op_reg <= op_next; note_reg <= note_next; vel_reg <= vel_next;
        held_reg <= held_next; now_reg <= now_next; frm_reg <= frm_next;
        delta_reg <= delta_next; pick_reg <= pick_next; old_reg <= old_next;
        idx_reg <= idx_next; match_reg <= match_next; free_reg <= free_next;
        valid_reg <= valid_next; oldst_reg <= oldst_next; ret_reg <= ret_next;
        act_reg <= act_next; out_reg <= out_next;
    end

    always_comb begin
        state_next = state_reg; clr_next = clr_reg; cnt_next = cnt_reg;
        pass_next = pass_reg; pedal_next = pedal_reg; op_next = op_reg;
        note_next = note_reg; vel_next = vel_reg; held_next = held_reg;
        now_next = now_reg; frm_next = frm_reg; delta_next = delta_reg;
        pick_next = pick_reg; old_next = old_reg; idx_next = idx_reg;
        match_next = match_reg; free_next = free_reg; valid_next = valid_reg;
        oldst_next = oldst_reg; ret_next = ret_reg; act_next = act_reg;
        out_next = out_reg;
        ov_next = ov_reg && !m_axis_tready;
        ctl = '0;
        wv = rd;
        sum = '0;
        ph = rd.phase;
        hit = (rd.mode != MODE_IDLE) && (rd.note == note_reg);
        case (state_reg)
            ST_FIX: begin
                ctl.we = 1'b1;
                ctl.waddr = clr_reg[VW-1:0];
                ctl.wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (VW+1)'(NUM_VOICES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    op_next = op_t'(s_axis_tdata[1:0]);
                    note_next = s_axis_tdata[8:2];
                    vel_next = s_axis_tdata[15:9];
                    held_next = s_axis_tdata[16];
                    now_next = s_axis_tdata[48:17];
                    frm_next = s_axis_tdata[59:49];
                    cnt_next = '0; pass_next = 1'b0;
                    match_next = 1'b0; free_next = 1'b0; valid_next = 1'b0;
                    idx_next = '0; pick_next = '0; old_next = '0;
                    ret_next = '0; act_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == '0) begin
                    delta_next = 27'({11'd0, step_reg} * {16'd0, frm_reg});
                end
                if (cnt_reg != (VW+1)'(NUM_VOICES)) begin
                    ctl.raddr = cnt_reg[VW-1:0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0) begin
                    case (op_reg)
                        OP_NOTE_ON: begin
                            if (hit && !match_reg) begin
                                match_next = 1'b1; pick_next = ri;
                            end
                            if (rd.mode == MODE_IDLE && !free_reg) begin
                                free_next = 1'b1; old_next = ri;
                            end
                            if (!free_reg && rd.mode != MODE_IDLE &&
                                (cnt_reg == (VW+1)'(1) || rd.start < oldst_reg)) begin
                                oldst_next = rd.start; idx_next = ri;
                            end
                        end
                        OP_NOTE_OFF: begin
                            if (hit) begin
                                if (!valid_reg) begin
                                    valid_next = 1'b1; idx_next = ri;
                                end
                                if (pedal_reg) begin
                                    wv.frozen = 1'b1; wv.mode = MODE_SUSTAIN;
                                end else begin
                                    wv.mode = MODE_RELEASE; wv.up = 1'b0;
                                end
                            end
                        end
                        OP_PEDAL: begin
                            if (!held_reg && rd.frozen) begin
                                wv.frozen = 1'b0; wv.mode = MODE_RELEASE;
                                wv.up = 1'b0;
                            end
                        end
                        default: begin
                            if (frm_reg <= 11'(MAX_FRAMES) && rd.mode != MODE_IDLE) begin
                                if (rd.up) begin
                                    sum = {12'd0, rd.phase} + {1'b0, delta_reg};
                                    ph = (sum > {12'd0, PHASE_FULL}) ? PHASE_FULL
                                                                     : sum[15:0];
                                end else begin
                                    ph = ({11'd0, rd.phase} > delta_reg)
                                        ? rd.phase - delta_reg[15:0] : 16'd0;
                                end
                                wv.phase = ph;
                                if (rd.mode == MODE_ATTACK) begin
                                    wv.mode = MODE_SUSTAIN;
                                end
                                if (rd.mode == MODE_RELEASE && ph <= thr_reg) begin
                                    wv.mode = MODE_IDLE;
                                    if (int'(ri) < 16) begin
                                        ret_next = ret_reg | (16'd1 << ri);
                                    end
                                end
                            end
                        end
                    endcase
                    if (op_reg != OP_NOTE_ON) begin
                        ctl.we = 1'b1; ctl.waddr = ri; ctl.wdata = wv;
                        if (wv.mode != MODE_IDLE) begin
                            act_next = act_reg + 1'b1;
                        end
                    end
                end
                if (cnt_reg == (VW+1)'(NUM_VOICES)) begin
                    if (op_reg == OP_PEDAL && !pass_reg) begin
                        pedal_next = held_reg;
                    end
                    state_next = (op_reg == OP_NOTE_ON) ? ST_ALLOC : ST_OUT;
                    cnt_next = '0;
                end
            end
            ST_ALLOC: begin
                if (match_reg) begin
                    idx_next = pick_reg;
                end else if (free_reg) begin
                    idx_next = old_reg;
                end
                ctl.we = 1'b1;
                ctl.waddr = match_reg ? pick_reg : (free_reg ? old_reg : idx_reg);
                ctl.wdata.mode = MODE_ATTACK;
                ctl.wdata.note = note_reg;
                ctl.wdata.vel = vel_reg;
                ctl.wdata.start = now_reg;
                ctl.wdata.up = 1'b1;
                valid_next = 1'b1;
                pass_next = 1'b1;
                state_next = ST_SCAN;
                op_next = OP_PEDAL;
                held_next = 1'b1;
            end
            ST_OUT: begin
                if (!ov_reg || m_axis_tready) begin
                    out_next = '0;
                    out_next[3:0] = 4'(idx_reg);
                    out_next[4] = valid_reg;
                    out_next[5] = pass_reg && match_reg;
                    out_next[6] = pass_reg && !match_reg && !free_reg;
                    out_next[22:7] = ret_reg;
                    out_next[27:23] = 5'(act_reg);
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
